/* rtl/edt_pkg.sv */
`timescale 1ns / 1ps

package edt_pkg;

   localparam int FAR_W  = 14;
   localparam int DIM_W  = 9;
   localparam int DIST_W = 24;
   localparam int SCALE  = 10;
   localparam int Q_BITS = 16;

   localparam logic [1:0] FN_LOAD = 2'd0;
   localparam logic [1:0] FN_RUN  = 2'd1;
   localparam logic [1:0] FN_READ = 2'd2;

   localparam logic [1:0] CSR_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_FAR    = 2'd2;

   typedef enum logic [1:0] {
      PH_FWD   = 2'd0,
      PH_RIGHT = 2'd1,
      PH_BWD   = 2'd2,
      PH_LEFT  = 2'd3
   } phase_type;

   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000000000000001,
      S_LOAD  = 16'b0000000000000010,
      S_RDREQ = 16'b0000000000000100,
      S_RDWT  = 16'b0000000000001000,
      S_MULX  = 16'b0000000000010000,
      S_MULY  = 16'b0000000000100000,
      S_CMP   = 16'b0000000001000000,
      S_SQRT  = 16'b0000000010000000,
      S_DIFF  = 16'b0000000100000000,
      S_DIV   = 16'b0000001000000000,
      S_VRD   = 16'b0000010000000000,
      S_VWT   = 16'b0000100000000000,
      S_NB    = 16'b0001000000000000,
      S_NWT   = 16'b0010000000000000,
      S_VWR   = 16'b0100000000000000,
      S_OUT   = 16'b1000000000000000
   } state_type;

   function automatic logic [2:0] nb_count(phase_type ph);
      logic [2:0] n;
      case (ph)
         PH_FWD:  n = 3'd4;
         PH_BWD:  n = 3'd4;
         default: n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic logic signed [1:0] nb_dx(phase_type ph, logic [2:0] i);
      logic signed [1:0] d;
      d = 2'sd0;
      case (ph)
         PH_FWD: begin
            case (i)
               3'd0:    d = -2'sd1;
               3'd1:    d = 2'sd0;
               3'd2:    d = -2'sd1;
               default: d = 2'sd1;
            endcase
         end
         PH_BWD: begin
            case (i)
               3'd0:    d = 2'sd1;
               3'd1:    d = 2'sd0;
               3'd2:    d = -2'sd1;
               default: d = 2'sd1;
            endcase
         end
         PH_RIGHT: d = 2'sd1;
         default:  d = -2'sd1;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] nb_dy(phase_type ph, logic [2:0] i);
      logic signed [1:0] d;
      d = 2'sd0;
      case (ph)
         PH_FWD: begin
            case (i)
               3'd0:    d = 2'sd0;
               default: d = -2'sd1;
            endcase
         end
         PH_BWD: begin
            case (i)
               3'd0:    d = 2'sd0;
               default: d = 2'sd1;
            endcase
         end
         default: d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

/* rtl/edt_ram.sv */
`timescale 1ns / 1ps

module edt_ram #(
   parameter int DEPTH = 2,
   parameter int AW    = 1,
   parameter int DW    = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/eight_point_distance_transform.sv */
`timescale 1ns / 1ps

// Eight-neighbor sequential Euclidean distance transform over a binary image.
// Words arrive on the req_ channel; each one gives exactly one word on the rsp_
// channel. A load word stores one pixel's inside flag, a run word sweeps the
// whole image through the forward and backward passes, and a read word returns
// the scaled distance difference of one pixel in Q8.16.
// The block takes one request word at a time and is not ready until that word
// has been worked through. All work goes through one sequencer, one multiplier,
// one bit-serial square root and one bit-serial divider, and one grid memory
// with one read port and one write port holds both offset grids.
// A load of a pixel in range writes both grids. A read works through the two
// square roots and the division. A run sweeps each grid through the forward
// and backward passes, paced by the memory port and the multiplier, which
// serve one neighbor at a time.
// The response sits in an output register; a new request is taken while it
// waits, and the block holds before its next response until rsp_tready.
// Reset is synchronous and clears control state and restores the registers
// to a 256 by 256 image with far distance 9999. Grid contents are undefined
// until loaded; there is no clearing pass.

module eight_point_distance_transform #(
   parameter int MAX_WIDTH   = 256,
   parameter int MAX_HEIGHT  = 256,
   parameter int OFFSET_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], col[9:2], row[17:10], inside_flag[18], zero fill above.
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // distance[23:0], done_res[24], zero fill above.
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [13:0] csr_wdata
);

   localparam int CELLS   = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW      = $clog2(CELLS);
   localparam int MW      = $clog2(2 * CELLS);
   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int YW      = $clog2(MAX_HEIGHT);
   localparam int OB      = OFFSET_BITS;
   localparam int DW      = 2 * OB;
   localparam int RW      = OB + edt_pkg::Q_BITS;
   localparam int REMW    = RW + 3;
   localparam int VW      = DW + 2 * edt_pkg::Q_BITS;
   localparam int NW      = RW + 4;
   localparam int SCW     = $clog2(NW + 1);
   localparam int FW      = edt_pkg::FAR_W;
   localparam int OFS_MAX = (1 << (OB - 1)) - 1;

   function automatic logic signed [OB-1:0] sat_ofs(logic signed [OB:0] v);
      logic signed [OB-1:0] r;
      if (v[OB] != v[OB-1]) begin
         r = v[OB] ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};
      end else begin
         r = v[OB-1:0];
      end
      return r;
   endfunction

   function automatic logic [AW-1:0] addr_of(logic [XW-1:0] x, logic [YW-1:0] y);
      return AW'(AW'(y) * AW'(MAX_WIDTH)) + AW'(x);
   endfunction

   function automatic logic [MW-1:0] full_addr(logic g, logic [AW-1:0] a);
      return g ? (MW'(a) + MW'(CELLS)) : MW'(a);
   endfunction

   edt_pkg::state_type state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [edt_pkg::DIM_W-1:0]  width_ff, height_ff;
   logic [FW-1:0]              far_ff;

   logic                       g_ff, g_in;
   logic [1:0]                 func_ff, func_in;
   logic [7:0]                 col_ff, col_in, row_ff, row_in;
   logic                       inside_ff, inside_in;
   logic [edt_pkg::DIST_W-1:0] res_ff, res_in, dist_ff, dist_in;
   logic [XW-1:0]              x_ff, x_in;
   logic [YW-1:0]              y_ff, y_in;
   edt_pkg::phase_type         ph_ff, ph_in;
   logic [2:0]                 nidx_ff, nidx_in;
   logic                       init_ff, init_in;
   logic signed [OB-1:0]       cx_ff, cx_in, cy_ff, cy_in, px_ff, px_in, py_ff, py_in;
   logic [DW-1:0]              sq_ff, sq_in, sq2_ff, sq2_in, pl_ff, pl_in;
   logic [VW-1:0]              val_ff, val_in;
   logic [RW-1:0]              root_ff, root_in, r1_ff, r1_in;
   logic [REMW-1:0]            rem_ff, rem_in;
   logic [SCW-1:0]             sc_ff, sc_in;
   logic [NW-1:0]              num_ff, num_in, q_ff, q_in;
   logic [FW-1:0]              drem_ff, drem_in;

   logic                       ram_we;
   logic [MW-1:0]              ram_waddr, ram_raddr;
   logic [DW-1:0]              ram_wdata, ram_rdata;

   logic [XW-1:0]              lx;
   logic [YW-1:0]              ly;
   logic [FW-1:0]              far_e;
   logic signed [OB-1:0]       far_ofs, rd_x, rd_y;
   logic                       req_in_store;
   logic [AW-1:0]              ld_addr, cen_addr, nb_addr;
   logic signed [1:0]          ox, oy;
   logic signed [XW+1:0]       nx;
   logic signed [YW+1:0]       ny;
   logic                       nb_ok;
   logic signed [DW-1:0]       prod;
   logic [DW-1:0]              len_sum;
   logic [REMW-1:0]            remn, trial;
   logic                       sq_ge;
   logic [RW-1:0]              root_next, rdiff;
   logic [FW:0]                dr;
   logic                       dv_ge;
   logic [NW-1:0]              q_next;

   edt_ram #(
      .DEPTH (2 * CELLS),
      .AW    (MW),
      .DW    (DW)
   ) u_grid (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (width_ff == '0) begin
         lx = '0;
      end else if (32'(width_ff) > MAX_WIDTH) begin
         lx = XW'(MAX_WIDTH - 1);
      end else begin
         lx = XW'(width_ff - 9'd1);
      end
      if (height_ff == '0) begin
         ly = '0;
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         ly = YW'(MAX_HEIGHT - 1);
      end else begin
         ly = YW'(height_ff - 9'd1);
      end
   end

   assign far_e        = (far_ff == '0) ? FW'(1) : far_ff;
   assign far_ofs      = (32'(far_e) > OFS_MAX) ? OB'(OFS_MAX) : OB'(far_e);
   assign req_in_store = (32'(req_tdata[9:2]) < MAX_WIDTH) &&
                         (32'(req_tdata[17:10]) < MAX_HEIGHT);
   assign ld_addr      = AW'(AW'(row_ff) * AW'(MAX_WIDTH)) + AW'(col_ff);
   assign cen_addr     = addr_of(x_ff, y_ff);
   assign rd_x         = ram_rdata[OB-1:0];
   assign rd_y         = ram_rdata[DW-1:OB];

   assign ox      = edt_pkg::nb_dx(ph_ff, nidx_ff);
   assign oy      = edt_pkg::nb_dy(ph_ff, nidx_ff);
   assign nx      = $signed({2'b00, x_ff}) + $signed({{XW{ox[1]}}, ox});
   assign ny      = $signed({2'b00, y_ff}) + $signed({{YW{oy[1]}}, oy});
   assign nb_ok   = !nx[XW+1] && (nx <= $signed({2'b00, lx})) &&
                    !ny[YW+1] && (ny <= $signed({2'b00, ly}));
   assign nb_addr = addr_of(nx[XW-1:0], ny[YW-1:0]);

   assign prod    = (state_ff == edt_pkg::S_MULX) ? cx_ff * cx_ff : cy_ff * cy_ff;
   assign len_sum = sq_ff + sq2_ff;

   assign remn      = {rem_ff[REMW-3:0], val_ff[VW-1:VW-2]};
   assign trial     = REMW'({root_ff, 2'b01});
   assign sq_ge     = remn >= trial;
   assign root_next = {root_ff[RW-2:0], sq_ge};
   assign rdiff     = (r1_ff > root_ff) ? (r1_ff - root_ff) : (root_ff - r1_ff);

   assign dr     = {drem_ff, num_ff[NW-1]};
   assign dv_ge  = dr >= {1'b0, far_e};
   assign q_next = {q_ff[NW-2:0], dv_ge};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      g_in         = g_ff;
      func_in      = func_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      inside_in    = inside_ff;
      res_in       = res_ff;
      dist_in      = dist_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      ph_in        = ph_ff;
      nidx_in      = nidx_ff;
      init_in      = init_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      sq_in        = sq_ff;
      sq2_in       = sq2_ff;
      pl_in        = pl_ff;
      val_in       = val_ff;
      root_in      = root_ff;
      r1_in        = r1_ff;
      rem_in       = rem_ff;
      sc_in        = sc_ff;
      num_in       = num_ff;
      q_in         = q_ff;
      drem_in      = drem_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;

      case (state_ff)
         edt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_tdata[1:0];
               col_in    = req_tdata[9:2];
               row_in    = req_tdata[17:10];
               inside_in = req_tdata[18];
               res_in    = '0;
               g_in      = 1'b0;
               x_in      = '0;
               y_in      = '0;
               ph_in     = edt_pkg::PH_FWD;
               case (req_tdata[1:0])
                  edt_pkg::FN_LOAD: begin
                     state_in = req_in_store ? edt_pkg::S_LOAD : edt_pkg::S_OUT;
                  end
                  edt_pkg::FN_RUN: begin
                     state_in = edt_pkg::S_VRD;
                  end
                  edt_pkg::FN_READ: begin
                     state_in = req_in_store ? edt_pkg::S_RDREQ : edt_pkg::S_OUT;
                  end
                  default: begin
                     state_in = edt_pkg::S_OUT;
                  end
               endcase
            end
         end
         edt_pkg::S_LOAD: begin
            ram_we    = 1'b1;
            ram_waddr = full_addr(g_ff, ld_addr);
            ram_wdata = (inside_ff ^ g_ff) ? {far_ofs, far_ofs} : '0;
            if (g_ff) begin
               state_in = edt_pkg::S_OUT;
            end else begin
               g_in = 1'b1;
            end
         end
         edt_pkg::S_RDREQ: begin
            ram_raddr = full_addr(g_ff, ld_addr);
            state_in  = edt_pkg::S_RDWT;
         end
         edt_pkg::S_RDWT: begin
            cx_in    = rd_x;
            cy_in    = rd_y;
            state_in = edt_pkg::S_MULX;
         end
         edt_pkg::S_MULX: begin
            sq_in    = $unsigned(prod);
            state_in = edt_pkg::S_MULY;
         end
         edt_pkg::S_MULY: begin
            sq2_in   = $unsigned(prod);
            state_in = edt_pkg::S_CMP;
         end
         edt_pkg::S_CMP: begin
            if (func_ff == edt_pkg::FN_READ) begin
               val_in   = {len_sum, {(2 * edt_pkg::Q_BITS){1'b0}}};
               root_in  = '0;
               rem_in   = '0;
               sc_in    = '0;
               state_in = edt_pkg::S_SQRT;
            end else begin
               if (init_ff || (len_sum < pl_ff)) begin
                  px_in = cx_ff;
                  py_in = cy_ff;
                  pl_in = len_sum;
               end
               init_in  = 1'b0;
               nidx_in  = init_ff ? 3'd0 : nidx_ff + 3'd1;
               state_in = edt_pkg::S_NB;
            end
         end
         edt_pkg::S_SQRT: begin
            val_in  = val_ff << 2;
            rem_in  = sq_ge ? (remn - trial) : remn;
            root_in = root_next;
            sc_in   = sc_ff + SCW'(1);
            if (sc_ff == SCW'(RW - 1)) begin
               if (g_ff) begin
                  state_in = edt_pkg::S_DIFF;
               end else begin
                  r1_in    = root_next;
                  g_in     = 1'b1;
                  state_in = edt_pkg::S_RDREQ;
               end
            end
         end
         edt_pkg::S_DIFF: begin
            num_in   = NW'(rdiff) * NW'(edt_pkg::SCALE);
            q_in     = '0;
            drem_in  = '0;
            sc_in    = '0;
            state_in = edt_pkg::S_DIV;
         end
         edt_pkg::S_DIV: begin
            num_in  = num_ff << 1;
            drem_in = dv_ge ? FW'(dr - {1'b0, far_e}) : FW'(dr);
            q_in    = q_next;
            sc_in   = sc_ff + SCW'(1);
            if (sc_ff == SCW'(NW - 1)) begin
               res_in   = (|q_next[NW-1:edt_pkg::DIST_W]) ? '1 :
                          q_next[edt_pkg::DIST_W-1:0];
               state_in = edt_pkg::S_OUT;
            end
         end
         edt_pkg::S_VRD: begin
            ram_raddr = full_addr(g_ff, cen_addr);
            state_in  = edt_pkg::S_VWT;
         end
         edt_pkg::S_VWT: begin
            cx_in    = rd_x;
            cy_in    = rd_y;
            init_in  = 1'b1;
            state_in = edt_pkg::S_MULX;
         end
         edt_pkg::S_NB: begin
            if (nidx_ff == edt_pkg::nb_count(ph_ff)) begin
               state_in = edt_pkg::S_VWR;
            end else if (nb_ok) begin
               ram_raddr = full_addr(g_ff, nb_addr);
               state_in  = edt_pkg::S_NWT;
            end else begin
               nidx_in = nidx_ff + 3'd1;
            end
         end
         edt_pkg::S_NWT: begin
            cx_in    = sat_ofs($signed({rd_x[OB-1], rd_x}) + $signed({{(OB-1){ox[1]}}, ox}));
            cy_in    = sat_ofs($signed({rd_y[OB-1], rd_y}) + $signed({{(OB-1){oy[1]}}, oy}));
            state_in = edt_pkg::S_MULX;
         end
         edt_pkg::S_VWR: begin
            ram_we    = 1'b1;
            ram_waddr = full_addr(g_ff, cen_addr);
            ram_wdata = {py_ff, px_ff};
            state_in  = edt_pkg::S_VRD;
            case (ph_ff)
               edt_pkg::PH_FWD: begin
                  if (x_ff == lx) begin
                     ph_in = edt_pkg::PH_RIGHT;
                  end else begin
                     x_in = x_ff + XW'(1);
                  end
               end
               edt_pkg::PH_RIGHT: begin
                  if (x_ff == '0) begin
                     if (y_ff == ly) begin
                        ph_in = edt_pkg::PH_BWD;
                        x_in  = lx;
                     end else begin
                        y_in  = y_ff + YW'(1);
                        ph_in = edt_pkg::PH_FWD;
                     end
                  end else begin
                     x_in = x_ff - XW'(1);
                  end
               end
               edt_pkg::PH_BWD: begin
                  if (x_ff == '0) begin
                     ph_in = edt_pkg::PH_LEFT;
                  end else begin
                     x_in = x_ff - XW'(1);
                  end
               end
               default: begin
                  if (x_ff == lx) begin
                     if (y_ff == '0) begin
                        if (g_ff) begin
                           state_in = edt_pkg::S_OUT;
                        end else begin
                           g_in  = 1'b1;
                           ph_in = edt_pkg::PH_FWD;
                           x_in  = '0;
                           y_in  = '0;
                        end
                     end else begin
                        y_in  = y_ff - YW'(1);
                        ph_in = edt_pkg::PH_BWD;
                     end
                  end else begin
                     x_in = x_ff + XW'(1);
                  end
               end
            endcase
         end
         edt_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               dist_in      = res_ff;
               state_in     = edt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = edt_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= edt_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         g_ff         <= 1'b0;
         width_ff     <= 9'd256;
         height_ff    <= 9'd256;
         far_ff       <= 14'd9999;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         g_ff         <= g_in;
         if (csr_we) begin
            case (csr_addr)
               edt_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[edt_pkg::DIM_W-1:0];
               edt_pkg::CSR_HEIGHT: height_ff <= csr_wdata[edt_pkg::DIM_W-1:0];
               edt_pkg::CSR_FAR:    far_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      inside_ff <= inside_in;
      res_ff    <= res_in;
      dist_ff   <= dist_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      ph_ff     <= ph_in;
      nidx_ff   <= nidx_in;
      init_ff   <= init_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      px_ff     <= px_in;
      py_ff     <= py_in;
      sq_ff     <= sq_in;
      sq2_ff    <= sq2_in;
      pl_ff     <= pl_in;
      val_ff    <= val_in;
      root_ff   <= root_in;
      r1_ff     <= r1_in;
      rem_ff    <= rem_in;
      sc_ff     <= sc_in;
      num_ff    <= num_in;
      q_ff      <= q_in;
      drem_ff   <= drem_in;
   end

   assign req_tready = (state_ff == edt_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, 1'b1, dist_ff};

`ifndef NO_ASSERTIONS
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == edt_pkg::S_OUT && (!rsp_valid_ff || rsp_tready)) |=> rsp_tvalid)
      else $error("finished word did not reach the output register");

   a_done_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[24])
      else $error("response word without done flag");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == edt_pkg::S_LOAD || state_ff == edt_pkg::S_VWR))
      else $error("grid write outside load or visit write-back");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a word is still in work");
`endif

endmodule
